/* hdl/lbs_pkg.sv */
package lbs_pkg;

  localparam int MAX_BONES      = 256;
  localparam int WORDS_PER_BONE = 12;
  localparam int BONE_AW        = $clog2(MAX_BONES);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_MORPH = 2'd2,
    REQ_INFL  = 2'd3
  } req_t;

  localparam logic CFG_BONE_COUNT  = 1'b0;
  localparam logic CFG_SKIN_ENABLE = 1'b1;

  // Snapshot of one finished vertex, handed to the transform pipeline.
  typedef struct packed {
    logic [23:0]       vid;
    logic              skinned;
    logic [2:0][31:0]  pos;
    logic [11:0][47:0] acc;
  } snap_t;

  function automatic logic [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  function automatic logic [31:0] sat32_37(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (v < -37'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* hdl/lbs_ram.sv */
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lbs_xform.sv */
module lbs_xform (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 snap_valid,
  output logic                 snap_stall,
  input  lbs_pkg::snap_t       snap,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [23:0]          out_vert_id,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic                 skinned
);

  logic av, bv, cv;
  logic en_a, en_b, en_c, en_o;

  lbs_pkg::snap_t a;

  logic signed [63:0] ph [3][3];
  logic signed [32:0] pl [3][3];
  logic signed [47:0] tr [3];
  logic [23:0]        b_vid;
  logic               b_sk;
  logic [2:0][31:0]   b_pos;

  logic signed [67:0] sum [3];
  logic [23:0]        c_vid;
  logic               c_sk;
  logic [2:0][31:0]   c_pos;

  logic signed [63:0] ph_next [3][3];
  logic signed [48:0] plw [3][3];
  logic signed [67:0] sum_next [3];
  logic signed [31:0] res [3];

  assign en_o = !out_valid || !out_stall;
  assign en_c = !cv || en_o;
  assign en_b = !bv || en_c;
  assign en_a = !av || en_b;
  assign snap_stall = !en_a;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        ph_next[c][r] = $signed(a.pos[r]) * $signed(a.acc[r*3+c][47:16]);
        plw[c][r]     = $signed(a.pos[r]) * $signed({1'b0, a.acc[r*3+c][15:0]});
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = 68'(ph[c][0]) + 68'(ph[c][1]) + 68'(ph[c][2])
                  + 68'(pl[c][0]) + 68'(pl[c][1]) + 68'(pl[c][2]) + 68'(tr[c]);
    end
  end

  // Saturate the exact sum once; an unskinned vertex keeps its position.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!c_sk) begin
        res[c] = $signed(c_pos[c]);
      end else if (sum[c] > 68'sd2147483647) begin
        res[c] = 32'sh7fff_ffff;
      end else if (sum[c] < -68'sd2147483648) begin
        res[c] = 32'sh8000_0000;
      end else begin
        res[c] = sum[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av        <= 1'b0;
      bv        <= 1'b0;
      cv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) begin
        av <= snap_valid;
      end
      if (en_b) begin
        bv <= av;
      end
      if (en_c) begin
        cv <= bv;
      end
      if (en_o) begin
        out_valid <= cv;
      end
    end
    if (en_a) begin
      a <= snap;
    end
    if (en_b) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          ph[c][r] <= ph_next[c][r];
          pl[c][r] <= plw[c][r][48:16];
        end
        tr[c] <= $signed(a.acc[9+c]);
      end
      b_vid <= a.vid;
      b_sk  <= a.skinned;
      b_pos <= a.pos;
    end
    if (en_c) begin
      for (int c = 0; c < 3; c++) begin
        sum[c] <= sum_next[c];
      end
      c_vid <= b_vid;
      c_sk  <= b_sk;
      c_pos <= b_pos;
    end
    if (en_o) begin
      out_vert_id <= c_vid;
      out_x       <= res[0];
      out_y       <= res[1];
      out_z       <= res[2];
      skinned     <= c_sk;
    end
  end

endmodule

/* hdl/linear_blend_skinning_morph.sv */
// Poses one vertex per stream of beats and accepts one beat every clock cycle when the
// output is not stalled. A load beat writes one matrix word straight into a bank of twelve
// 256-entry RAMs (one per matrix word), so a bone's full matrix is read at once;
// a load may be followed at once by an influence on the same bone. Morph and influence beats
// are held in the input stage and update the vertex state once that stage is taken. The
// beat marked last presents its result after passing five registers: a state update
// stage, a snapshot stage, a multiply stage (position by accumulator, split into high and
// low halves), a sum stage and the saturating output register. The bone store is not
// cleared; influences must only name bones whose twelve words have been loaded.
module linear_blend_skinning_morph (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [23:0]         vert_id,
  input  logic [7:0]          bone_index,
  input  logic [3:0]          entry_index,
  input  logic signed [31:0]  matrix_word,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [19:0]  weight,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         out_vert_id,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                skinned
);

  logic [8:0] bone_count;
  logic       skin_enable;

  logic accept, take1, x_stall, s1_emit;

  logic                s1_valid;
  lbs_pkg::req_t       s1_type;
  logic [23:0]         s1_vid;
  logic [7:0]          s1_bone;
  logic [2:0][31:0]    s1_pos;
  logic signed [19:0]  s1_w;
  logic                s1_last;

  logic [31:0] rd [lbs_pkg::WORDS_PER_BONE];

  logic signed [47:0] acc [lbs_pkg::WORDS_PER_BONE];
  logic signed [31:0] pos [3];
  logic signed [23:0] tw;
  logic [23:0]        vid;

  logic signed [47:0] acc_next [lbs_pkg::WORDS_PER_BONE];
  logic signed [31:0] pos_next [3];
  logic signed [23:0] tw_next;
  logic [23:0]        vid_next;

  logic signed [51:0] mprod [lbs_pkg::WORDS_PER_BONE];
  logic signed [51:0] pprod [3];
  logic signed [24:0] tw_sum;
  logic               bone_ok;

  lbs_pkg::snap_t snap;

  assign accept  = in_valid && !in_stall;
  assign s1_emit = s1_last;
  assign take1   = s1_valid && !(s1_emit && x_stall);
  assign in_stall = s1_valid && !take1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count  <= 9'd0;
      skin_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbs_pkg::CFG_BONE_COUNT:  bone_count  <= cfg_data;
        lbs_pkg::CFG_SKIN_ENABLE: skin_enable <= cfg_data[0];
      endcase
    end
  end

  for (genvar i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin : g_bank
    lbs_ram #(
      .WIDTH(32),
      .DEPTH(lbs_pkg::MAX_BONES)
    ) u_bank (
      .clk  (clk),
      .we   (accept && req_type == lbs_pkg::REQ_LOAD && entry_index == 4'(i)),
      .waddr(bone_index[lbs_pkg::BONE_AW-1:0]),
      .wdata(matrix_word),
      .re   (accept),
      .raddr(bone_index[lbs_pkg::BONE_AW-1:0]),
      .rdata(rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_type  <= lbs_pkg::REQ_LOAD;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid && req_type != lbs_pkg::REQ_LOAD;
      end
      if (accept) begin
        s1_type <= lbs_pkg::req_t'(req_type);
      end
    end
    if (accept) begin
      s1_vid  <= vert_id;
      s1_bone <= bone_index;
      s1_pos  <= {pos_z, pos_y, pos_x};
      s1_w    <= weight;
      s1_last <= last;
    end
  end

  assign bone_ok = {1'b0, s1_bone} < bone_count;
  assign tw_sum  = 25'(tw) + 25'(s1_w);

  always_comb begin
    for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
      mprod[i]    = s1_w * $signed(rd[i]);
      acc_next[i] = acc[i];
    end
    for (int i = 0; i < 3; i++) begin
      pprod[i]    = s1_w * $signed(s1_pos[i]);
      pos_next[i] = pos[i];
    end
    tw_next  = tw;
    vid_next = vid;
    unique case (s1_type)
      lbs_pkg::REQ_LOAD: begin
      end
      lbs_pkg::REQ_START: begin
        for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
          acc_next[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
          pos_next[i] = $signed(s1_pos[i]);
        end
        tw_next  = '0;
        vid_next = s1_vid;
      end
      lbs_pkg::REQ_MORPH: begin
        if (s1_w != '0) begin
          for (int i = 0; i < 3; i++) begin
            pos_next[i] = lbs_pkg::sat32_37(37'(pos[i]) + 37'($signed(pprod[i][51:16])));
          end
        end
      end
      lbs_pkg::REQ_INFL: begin
        if (bone_ok) begin
          for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
            acc_next[i] = lbs_pkg::sat48(49'(acc[i]) + 49'($signed(mprod[i][51:16])));
          end
          if (tw_sum[24] != tw_sum[23]) begin
            tw_next = tw_sum[24] ? 24'sh80_0000 : 24'sh7f_ffff;
          end else begin
            tw_next = tw_sum[23:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
        acc[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
      end
      tw  <= '0;
      vid <= '0;
    end else if (take1) begin
      acc <= acc_next;
      pos <= pos_next;
      tw  <= tw_next;
      vid <= vid_next;
    end
  end

  always_comb begin
    snap.vid     = vid_next;
    snap.skinned = skin_enable && (tw_next > 24'sd0);
    for (int i = 0; i < 3; i++) begin
      snap.pos[i] = pos_next[i];
    end
    for (int i = 0; i < lbs_pkg::WORDS_PER_BONE; i++) begin
      snap.acc[i] = acc_next[i];
    end
  end

  lbs_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (s1_valid && s1_emit),
    .snap_stall (x_stall),
    .snap       (snap),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_vert_id(out_vert_id),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .skinned    (skinned)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall) else $error("input stalled with no beat held");

  a_no_load_in_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_type != lbs_pkg::REQ_LOAD) else $error("load beat entered state stage");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (take1 && s1_type == lbs_pkg::REQ_START) |=> tw == 24'sd0)
    else $error("start beat did not clear the weight total");
`endif

endmodule
